/* rtl/svib_pkg.sv */
// Shared types, constants and helpers for the shadow volume index builder.
`default_nettype none

package svib_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_FACES    = 2048;

    localparam int COORD_W   = 24;
    localparam int IDX_W     = 11;
    localparam int SLOT_W    = 10;
    localparam int EXT_W     = 23;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRUDE    = 3'd4;

    localparam logic [1:0] ACT_VERTEX = 2'd0;
    localparam logic [1:0] ACT_FACE   = 2'd1;
    localparam logic [1:0] ACT_EDGE   = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic RES_VERTEX = 1'b0;
    localparam logic RES_INDEX  = 1'b1;

    typedef enum logic [1:0] {
        KIND_VERTEX,
        KIND_FACE,
        KIND_EDGE
    } kind_t;

    typedef struct packed {
        kind_t                      kind;
        logic [SLOT_W-1:0]          slot;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic [IDX_W-1:0]           a;
        logic [IDX_W-1:0]           b;
        logic [IDX_W-1:0]           c;
        logic [IDX_W-1:0]           face;
        logic [IDX_W-1:0]           other;
        logic                       present;
    } item_t;

    typedef struct packed {
        logic                       directional;
        logic signed [COORD_W-1:0]  lx;
        logic signed [COORD_W-1:0]  ly;
        logic signed [COORD_W-1:0]  lz;
        logic [EXT_W-1:0]           ext;
    } light_t;

    typedef enum logic {
        ITER_SQRT,
        ITER_DIV
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_V_WRITE,
        ST_V_DMUL,
        ST_V_DUSE,
        ST_V_SMUL,
        ST_V_SUSE,
        ST_V_SQRT,
        ST_V_SWAIT,
        ST_V_EMUL,
        ST_V_EUSE,
        ST_V_DWAIT,
        ST_V_EMIT,
        ST_F_RDA,
        ST_F_RDB,
        ST_F_RDC,
        ST_F_CAP,
        ST_F_XMUL,
        ST_F_XUSE,
        ST_F_DMUL,
        ST_F_DUSE,
        ST_F_WRITE,
        ST_E_RD0,
        ST_E_RD1,
        ST_E_CAP,
        ST_EMIT
    } state_t;

    function automatic logic signed [COORD_W-1:0] sat24(input logic signed [55:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 56'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -56'sd8388608)
            r = 24'sh800000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/svib_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module svib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/svib_iter.sv */
// Iterative unit: integer square root (two bits a step) or restoring divide (one bit a step).
`default_nettype none

module svib_iter (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire svib_pkg::iter_ctl_t  ctl,
    input  wire logic [59:0]          sq_in,
    input  wire logic [53:0]          dividend,
    input  wire logic [29:0]          divisor,
    output logic                      busy,
    output logic                      done,
    output logic [53:0]               result
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    svib_pkg::iter_op_t op_reg;
    logic [5:0]         cnt_reg;
    logic [60:0]        a_reg;
    logic [60:0]        res_reg;
    logic [60:0]        bit_reg;
    logic [29:0]        rem_reg;
    logic [29:0]        den_reg;

    logic [61:0]        sq_sum;
    logic               sq_take;
    logic [30:0]        rem_sh;
    logic               div_take;
    logic               last_step;

    assign sq_sum   = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sq_take  = {1'b0, a_reg} >= sq_sum;
    assign rem_sh   = {rem_reg, a_reg[53]};
    assign div_take = rem_sh >= {1'b0, den_reg};
    assign last_step = (op_reg == svib_pkg::ITER_SQRT) ? bit_reg[0] : (cnt_reg == 6'd0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && last_step)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            op_reg  <= ctl.op;
            cnt_reg <= 6'd53;
            res_reg <= '0;
            rem_reg <= '0;
            den_reg <= divisor;
            bit_reg <= 61'd1 << 60;
            if (ctl.op == svib_pkg::ITER_SQRT)
                a_reg <= {1'b0, sq_in};
            else
                a_reg <= {7'd0, dividend};
        end
        else if (busy_reg)
        begin
            if (op_reg == svib_pkg::ITER_SQRT)
            begin
                if (sq_take)
                begin
                    a_reg   <= a_reg - sq_sum[60:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                if (div_take)
                    rem_reg <= 30'(rem_sh - {1'b0, den_reg});
                else
                    rem_reg <= rem_sh[29:0];
                res_reg <= {res_reg[59:0], div_take};
                a_reg   <= {a_reg[59:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg[53:0];

endmodule

`default_nettype wire

/* rtl/svib_front.sv */
// Input side: accept and classify items into a two-entry queue.
`default_nettype none

module svib_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [1:0]              action,
    input  wire logic [9:0]              vertex_slot,
    input  wire logic signed [23:0]      pos_x,
    input  wire logic signed [23:0]      pos_y,
    input  wire logic signed [23:0]      pos_z,
    input  wire logic [10:0]             corner_a,
    input  wire logic [10:0]             corner_b,
    input  wire logic [10:0]             corner_c,
    input  wire logic [10:0]             face_number,
    input  wire logic [10:0]             other_face,
    input  wire logic                    other_present,
    output logic                         q_valid,
    output svib_pkg::item_t              q_item,
    input  wire logic                    q_pop
);

    svib_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg, count_next;
    svib_pkg::item_t item_in;
    logic            push;

    always_comb
    begin
        item_in.slot    = vertex_slot;
        item_in.px      = pos_x;
        item_in.py      = pos_y;
        item_in.pz      = pos_z;
        item_in.a       = corner_a;
        item_in.b       = corner_b;
        item_in.c       = corner_c;
        item_in.face    = face_number;
        item_in.other   = other_face;
        item_in.present = other_present;
        unique case (action)
            svib_pkg::ACT_VERTEX: item_in.kind = svib_pkg::KIND_VERTEX;
            svib_pkg::ACT_FACE:   item_in.kind = svib_pkg::KIND_FACE;
            svib_pkg::ACT_EDGE:   item_in.kind = svib_pkg::KIND_EDGE;
            default:              item_in.kind = svib_pkg::KIND_VERTEX;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    // drop unused actions at the door: they cause nothing
    assign push     = in_valid && !in_stall && (action != svib_pkg::ACT_NONE);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
            count_next = count_reg + 2'd1;
        else if (!push && q_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= item_in;
    end

endmodule

`default_nettype wire

/* rtl/svib_back.sv */
// Execution side: sequencer, shared multiplier, stores and result register.
`default_nettype none

module svib_back #(
    parameter int MAX_VERTICES = svib_pkg::DEF_MAX_VERTICES,
    parameter int MAX_FACES    = svib_pkg::DEF_MAX_FACES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire svib_pkg::light_t    light,
    input  wire logic                q_valid,
    input  wire svib_pkg::item_t     q_item,
    output logic                     q_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     result_kind,
    output logic [10:0]              index_value,
    output logic signed [23:0]       out_x,
    output logic signed [23:0]       out_y,
    output logic signed [23:0]       out_z,
    output logic                     last_of_run
);

    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

    svib_pkg::state_t state_reg, state_next;
    svib_pkg::item_t  item_reg;

    logic [2:0]               k_reg;
    logic [2:0]               emit_reg;
    logic signed [23:0]       pv_reg [3];
    logic signed [24:0]       d_reg [3];
    logic signed [23:0]       o_reg [3];
    logic [49:0]              s_reg;
    logic [29:0]              r_reg;
    logic                     neg_reg;
    logic signed [23:0]       p1_reg [3];
    logic signed [23:0]       p2_reg [3];
    logic signed [23:0]       p3_reg [3];
    logic signed [49:0]       tmp_reg;
    logic signed [50:0]       n_reg [3];
    logic signed [77:0]       acc_reg;
    logic                     f0_reg;
    logic [10:0]              idx_reg [6];
    logic signed [53:0]       prod_reg;

    logic                     out_valid_reg;
    logic                     out_kind_reg;
    logic [10:0]              out_index_reg;
    logic signed [23:0]       out_x_reg, out_y_reg, out_z_reg;
    logic                     out_last_reg;

    logic signed [23:0]       lv [3];
    logic signed [24:0]       u [3];
    logic signed [24:0]       v [3];
    logic signed [24:0]       w [3];
    logic signed [26:0]       mul_a, mul_b;
    logic signed [26:0]       ext_s;
    logic signed [50:0]       nsel;

    logic                     out_free, out_load;
    logic                     v_we, f_we, f_wdata;
    logic [VAW-1:0]           v_addr;
    logic [FAW-1:0]           f_addr;
    logic [71:0]              v_rdata;
    logic                     f_rdata;
    svib_pkg::iter_ctl_t      iter_ctl;
    logic                     iter_busy, iter_done;
    logic [53:0]              iter_result;
    logic [53:0]              div_num;
    logic [53:0]              prod_mag;

    logic                     slot_ok, a_ok, b_ok, c_ok, face_ok, other_ok;
    logic                     fac_now, f1_now;
    logic [1:0]               kc;

    assign kc = k_reg[1:0];
    assign lv[0] = light.lx;
    assign lv[1] = light.ly;
    assign lv[2] = light.lz;
    assign ext_s = $signed({4'd0, light.ext});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i] = 25'(p2_reg[i]) - 25'(p1_reg[i]);
            v[i] = 25'(p3_reg[i]) - 25'(p1_reg[i]);
            w[i] = light.directional ? 25'(lv[i]) : 25'(lv[i]) - 25'(p1_reg[i]);
        end
    end

    assign slot_ok  = 32'(item_reg.slot) < MAX_VERTICES;
    assign a_ok     = 32'(item_reg.a[10:1]) < MAX_VERTICES;
    assign b_ok     = 32'(item_reg.b[10:1]) < MAX_VERTICES;
    assign c_ok     = 32'(item_reg.c[10:1]) < MAX_VERTICES;
    assign face_ok  = 32'(item_reg.face) < MAX_FACES;
    assign other_ok = 32'(item_reg.other) < MAX_FACES;
    assign fac_now  = !acc_reg[77] && (acc_reg != '0);
    assign f1_now   = item_reg.present && other_ok && f_rdata;
    assign nsel     = n_reg[k_reg[2:1]];
    assign prod_mag = prod_reg[53] ? 54'(-prod_reg) : 54'(prod_reg);
    // rounded quotient: scale by 32 and add half the divisor
    assign div_num  = {prod_mag[48:0], 5'd0} + 54'(r_reg >> 1);
    assign out_free = !out_valid_reg || !out_stall;

    svib_ram #(.WIDTH(72), .DEPTH(MAX_VERTICES)) u_vertex_ram (
        .clk   (clk),
        .we    (v_we),
        .addr  (v_addr),
        .wdata ({item_reg.px, item_reg.py, item_reg.pz}),
        .rdata (v_rdata)
    );

    svib_ram #(.WIDTH(1), .DEPTH(MAX_FACES)) u_facing_ram (
        .clk   (clk),
        .we    (f_we),
        .addr  (f_addr),
        .wdata (f_wdata),
        .rdata (f_rdata)
    );

    svib_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (iter_ctl),
        .sq_in    ({s_reg, 10'd0}),
        .dividend (div_num),
        .divisor  (r_reg),
        .busy     (iter_busy),
        .done     (iter_done),
        .result   (iter_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svib_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (q_item.kind)
                        svib_pkg::KIND_VERTEX: state_next = svib_pkg::ST_V_WRITE;
                        svib_pkg::KIND_FACE:   state_next = svib_pkg::ST_F_RDA;
                        svib_pkg::KIND_EDGE:   state_next = svib_pkg::ST_E_RD0;
                        default:               state_next = svib_pkg::ST_IDLE;
                    endcase
                end
            end
            svib_pkg::ST_V_WRITE:
                state_next = light.directional ? svib_pkg::ST_V_DMUL : svib_pkg::ST_V_SMUL;
            svib_pkg::ST_V_DMUL: state_next = svib_pkg::ST_V_DUSE;
            svib_pkg::ST_V_DUSE:
                state_next = (k_reg == 3'd2) ? svib_pkg::ST_V_EMIT : svib_pkg::ST_V_DMUL;
            svib_pkg::ST_V_SMUL: state_next = svib_pkg::ST_V_SUSE;
            svib_pkg::ST_V_SUSE:
                state_next = (k_reg == 3'd2) ? svib_pkg::ST_V_SQRT : svib_pkg::ST_V_SMUL;
            svib_pkg::ST_V_SQRT: state_next = svib_pkg::ST_V_SWAIT;
            svib_pkg::ST_V_SWAIT:
            begin
                if (iter_done)
                    state_next = (iter_result[29:0] == '0) ? svib_pkg::ST_V_EMIT
                                                           : svib_pkg::ST_V_EMUL;
            end
            svib_pkg::ST_V_EMUL: state_next = svib_pkg::ST_V_EUSE;
            svib_pkg::ST_V_EUSE: state_next = svib_pkg::ST_V_DWAIT;
            svib_pkg::ST_V_DWAIT:
            begin
                if (iter_done)
                    state_next = (k_reg == 3'd2) ? svib_pkg::ST_V_EMIT : svib_pkg::ST_V_EMUL;
            end
            svib_pkg::ST_V_EMIT:
            begin
                if (out_free)
                    state_next = svib_pkg::ST_IDLE;
            end
            svib_pkg::ST_F_RDA:  state_next = svib_pkg::ST_F_RDB;
            svib_pkg::ST_F_RDB:  state_next = svib_pkg::ST_F_RDC;
            svib_pkg::ST_F_RDC:  state_next = svib_pkg::ST_F_CAP;
            svib_pkg::ST_F_CAP:  state_next = svib_pkg::ST_F_XMUL;
            svib_pkg::ST_F_XMUL: state_next = svib_pkg::ST_F_XUSE;
            svib_pkg::ST_F_XUSE:
                state_next = (k_reg == 3'd5) ? svib_pkg::ST_F_DMUL : svib_pkg::ST_F_XMUL;
            svib_pkg::ST_F_DMUL: state_next = svib_pkg::ST_F_DUSE;
            svib_pkg::ST_F_DUSE:
                state_next = (k_reg == 3'd5) ? svib_pkg::ST_F_WRITE : svib_pkg::ST_F_DMUL;
            svib_pkg::ST_F_WRITE:
                state_next = fac_now ? svib_pkg::ST_EMIT : svib_pkg::ST_IDLE;
            svib_pkg::ST_E_RD0:  state_next = svib_pkg::ST_E_RD1;
            svib_pkg::ST_E_RD1:  state_next = svib_pkg::ST_E_CAP;
            svib_pkg::ST_E_CAP:
                state_next = (f0_reg ^ f1_now) ? svib_pkg::ST_EMIT : svib_pkg::ST_IDLE;
            svib_pkg::ST_EMIT:
            begin
                if (out_free && (emit_reg == 3'd5))
                    state_next = svib_pkg::ST_IDLE;
            end
            default: state_next = svib_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop        = 1'b0;
        v_we         = 1'b0;
        v_addr       = VAW'(item_reg.a[10:1]);
        f_we         = 1'b0;
        f_wdata      = fac_now;
        f_addr       = FAW'(item_reg.face);
        iter_ctl     = '{start: 1'b0, op: svib_pkg::ITER_SQRT};
        out_load     = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            svib_pkg::ST_IDLE:    q_pop = q_valid;
            svib_pkg::ST_V_WRITE:
            begin
                v_we   = slot_ok;
                v_addr = VAW'(item_reg.slot);
            end
            svib_pkg::ST_V_DMUL:
            begin
                mul_a = ext_s;
                mul_b = 27'(lv[kc]);
            end
            svib_pkg::ST_V_SMUL:
            begin
                mul_a = 27'(d_reg[kc]);
                mul_b = 27'(d_reg[kc]);
            end
            svib_pkg::ST_V_SQRT:  iter_ctl = '{start: 1'b1, op: svib_pkg::ITER_SQRT};
            svib_pkg::ST_V_EMUL:
            begin
                mul_a = ext_s;
                mul_b = 27'(d_reg[kc]);
            end
            svib_pkg::ST_V_EUSE:  iter_ctl = '{start: 1'b1, op: svib_pkg::ITER_DIV};
            svib_pkg::ST_V_EMIT:  out_load = out_free;
            svib_pkg::ST_F_RDA:   v_addr = VAW'(item_reg.a[10:1]);
            svib_pkg::ST_F_RDB:   v_addr = VAW'(item_reg.b[10:1]);
            svib_pkg::ST_F_RDC:   v_addr = VAW'(item_reg.c[10:1]);
            svib_pkg::ST_F_XMUL:
            begin
                unique case (k_reg)
                    3'd0:    begin mul_a = 27'(u[1]); mul_b = 27'(v[2]); end
                    3'd1:    begin mul_a = 27'(u[2]); mul_b = 27'(v[1]); end
                    3'd2:    begin mul_a = 27'(u[2]); mul_b = 27'(v[0]); end
                    3'd3:    begin mul_a = 27'(u[0]); mul_b = 27'(v[2]); end
                    3'd4:    begin mul_a = 27'(u[0]); mul_b = 27'(v[1]); end
                    3'd5:    begin mul_a = 27'(u[1]); mul_b = 27'(v[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            svib_pkg::ST_F_DMUL:
            begin
                // split the normal into a low unsigned part and a high signed part
                if (k_reg[0])
                    mul_a = 27'($signed(nsel[50:25]));
                else
                    mul_a = $signed({2'd0, nsel[24:0]});
                mul_b = 27'(w[k_reg[2:1]]);
            end
            svib_pkg::ST_F_WRITE:
            begin
                f_we   = face_ok;
                f_addr = FAW'(item_reg.face);
            end
            svib_pkg::ST_E_RD0:   f_addr = FAW'(item_reg.face);
            svib_pkg::ST_E_RD1:   f_addr = FAW'(item_reg.other);
            svib_pkg::ST_EMIT:    out_load = out_free;
            default:              q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svib_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [53:0]        q;
        logic signed [55:0] qs;
        prod_reg <= mul_a * mul_b;
        q  = (prod_mag + 54'd16384) >> 15;
        qs = $signed({2'd0, q});
        unique case (state_reg)
            svib_pkg::ST_IDLE:
            begin
                item_reg  <= q_item;
                pv_reg[0] <= q_item.px;
                pv_reg[1] <= q_item.py;
                pv_reg[2] <= q_item.pz;
            end
            svib_pkg::ST_V_WRITE:
            begin
                for (int i = 0; i < 3; i++)
                    d_reg[i] <= 25'(pv_reg[i]) - 25'(lv[i]);
                k_reg <= 3'd0;
                s_reg <= '0;
            end
            svib_pkg::ST_V_DUSE:
            begin
                // push against the light vector
                o_reg[kc] <= svib_pkg::sat24(56'(pv_reg[kc]) + (prod_reg[53] ? qs : -qs));
                k_reg     <= k_reg + 3'd1;
            end
            svib_pkg::ST_V_SUSE:
            begin
                s_reg <= s_reg + prod_reg[49:0];
                k_reg <= k_reg + 3'd1;
            end
            svib_pkg::ST_V_SWAIT:
            begin
                if (iter_done)
                begin
                    r_reg <= iter_result[29:0];
                    k_reg <= 3'd0;
                    for (int i = 0; i < 3; i++)
                        o_reg[i] <= pv_reg[i];
                end
            end
            svib_pkg::ST_V_EUSE:  neg_reg <= prod_reg[53];
            svib_pkg::ST_V_DWAIT:
            begin
                if (iter_done)
                begin
                    o_reg[kc] <= svib_pkg::sat24(56'(pv_reg[kc]) +
                                 (neg_reg ? -$signed({2'd0, iter_result})
                                          : $signed({2'd0, iter_result})));
                    k_reg     <= k_reg + 3'd1;
                end
            end
            svib_pkg::ST_F_RDB:
            begin
                p1_reg[0] <= a_ok ? $signed(v_rdata[71:48]) : 24'sd0;
                p1_reg[1] <= a_ok ? $signed(v_rdata[47:24]) : 24'sd0;
                p1_reg[2] <= a_ok ? $signed(v_rdata[23:0])  : 24'sd0;
            end
            svib_pkg::ST_F_RDC:
            begin
                p2_reg[0] <= b_ok ? $signed(v_rdata[71:48]) : 24'sd0;
                p2_reg[1] <= b_ok ? $signed(v_rdata[47:24]) : 24'sd0;
                p2_reg[2] <= b_ok ? $signed(v_rdata[23:0])  : 24'sd0;
            end
            svib_pkg::ST_F_CAP:
            begin
                p3_reg[0] <= c_ok ? $signed(v_rdata[71:48]) : 24'sd0;
                p3_reg[1] <= c_ok ? $signed(v_rdata[47:24]) : 24'sd0;
                p3_reg[2] <= c_ok ? $signed(v_rdata[23:0])  : 24'sd0;
                k_reg     <= 3'd0;
            end
            svib_pkg::ST_F_XUSE:
            begin
                if (!k_reg[0])
                    tmp_reg <= prod_reg[49:0];
                else
                    n_reg[k_reg[2:1]] <= 51'(tmp_reg) - 51'($signed(prod_reg[49:0]));
                if (k_reg == 3'd5)
                begin
                    k_reg   <= 3'd0;
                    acc_reg <= '0;
                end
                else
                begin
                    k_reg <= k_reg + 3'd1;
                end
            end
            svib_pkg::ST_F_DUSE:
            begin
                acc_reg <= acc_reg + (k_reg[0] ? (78'(prod_reg) <<< 25) : 78'(prod_reg));
                k_reg   <= k_reg + 3'd1;
            end
            svib_pkg::ST_F_WRITE:
            begin
                idx_reg[0] <= item_reg.a;
                idx_reg[1] <= item_reg.c;
                idx_reg[2] <= item_reg.b;
                idx_reg[3] <= item_reg.a + 11'd1;
                idx_reg[4] <= item_reg.b + 11'd1;
                idx_reg[5] <= item_reg.c + 11'd1;
                emit_reg   <= 3'd0;
            end
            svib_pkg::ST_E_RD1:   f0_reg <= face_ok && f_rdata;
            svib_pkg::ST_E_CAP:
            begin
                logic [10:0] e0;
                logic [10:0] e1;
                e0 = f0_reg ? item_reg.a : item_reg.b;
                e1 = f0_reg ? item_reg.b : item_reg.a;
                idx_reg[0] <= e0;
                idx_reg[1] <= e1;
                idx_reg[2] <= e0 + 11'd1;
                idx_reg[3] <= e0 + 11'd1;
                idx_reg[4] <= e1;
                idx_reg[5] <= e1 + 11'd1;
                emit_reg   <= 3'd0;
            end
            svib_pkg::ST_EMIT:
            begin
                if (out_free)
                    emit_reg <= emit_reg + 3'd1;
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase

        if (out_load)
        begin
            if (state_reg == svib_pkg::ST_V_EMIT)
            begin
                out_kind_reg  <= svib_pkg::RES_VERTEX;
                out_index_reg <= {item_reg.slot, 1'b1};
                out_x_reg     <= o_reg[0];
                out_y_reg     <= o_reg[1];
                out_z_reg     <= o_reg[2];
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_kind_reg  <= svib_pkg::RES_INDEX;
                out_index_reg <= idx_reg[emit_reg];
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_z_reg     <= '0;
                out_last_reg  <= (emit_reg == 3'd5);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign index_value = out_index_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign last_of_run = out_last_reg;

    a_iter_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == svib_pkg::ST_V_SQRT || state_reg == svib_pkg::ST_V_EUSE) |-> !iter_busy)
        else $error("iterative unit started while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("result register loaded while a result is held");

    a_vertex_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == svib_pkg::RES_VERTEX) |-> out_last_reg)
        else $error("extruded vertex not marked last");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != svib_pkg::ST_IDLE))
        else $error("item taken from queue but sequencer stayed idle");

endmodule

`default_nettype wire

/* rtl/shadow_volume_index_builder_core.sv */
// Top level: light registers, input queue and sequencer of the shadow volume index builder.
// Face item: decides facing, then up to six results one a cycle while out_stall is low.
// Edge item: reads both facing bits, then up to six results one a cycle while out_stall is low.
// Vertex, light vector: one multiply per axis; point light: the bit-serial square root
// (31 steps) and, unless the distance is zero, three 54-step divides in the iterative unit.
// Reset is asynchronous, active low; it clears control registers and loads light defaults only,
// vertex and facing stores hold no defined contents until written.
`default_nettype none

module shadow_volume_index_builder_core #(
    parameter int MAX_VERTICES = svib_pkg::DEF_MAX_VERTICES,
    parameter int MAX_FACES    = svib_pkg::DEF_MAX_FACES
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          action,
    input  wire logic [9:0]          vertex_slot,
    input  wire logic signed [23:0]  pos_x,
    input  wire logic signed [23:0]  pos_y,
    input  wire logic signed [23:0]  pos_z,
    input  wire logic [10:0]         corner_a,
    input  wire logic [10:0]         corner_b,
    input  wire logic [10:0]         corner_c,
    input  wire logic [10:0]         face_number,
    input  wire logic [10:0]         other_face,
    input  wire logic                other_present,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     result_kind,
    output logic [10:0]              index_value,
    output logic signed [23:0]       out_x,
    output logic signed [23:0]       out_y,
    output logic signed [23:0]       out_z,
    output logic                     last_of_run
);

    svib_pkg::light_t light_reg;
    logic             q_valid, q_pop;
    svib_pkg::item_t  q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg.directional <= 1'b1;
            light_reg.lx          <= 24'sd0;
            light_reg.ly          <= 24'sd0;
            light_reg.lz          <= 24'sd32767;
            light_reg.ext         <= 23'd524288;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                svib_pkg::CFG_LIGHT_KIND: light_reg.directional <= cfg_data[0];
                svib_pkg::CFG_LIGHT_X:    light_reg.lx <= $signed(cfg_data);
                svib_pkg::CFG_LIGHT_Y:    light_reg.ly <= $signed(cfg_data);
                svib_pkg::CFG_LIGHT_Z:    light_reg.lz <= $signed(cfg_data);
                svib_pkg::CFG_EXTRUDE:    light_reg.ext <= cfg_data[22:0];
                default:                  light_reg <= light_reg;
            endcase
        end
    end

    svib_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .vertex_slot   (vertex_slot),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .corner_a      (corner_a),
        .corner_b      (corner_b),
        .corner_c      (corner_c),
        .face_number   (face_number),
        .other_face    (other_face),
        .other_present (other_present),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    svib_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_FACES    (MAX_FACES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .light       (light_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .index_value (index_value),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire
